>>> hdl/ccfr_pkg.sv
package ccfr_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned S_TDATA_W   = 8;
  localparam int unsigned M_TDATA_W   = 16;
  localparam int unsigned M_TUSER_W   = 1;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned STORE_DEPTH_DEF = 32;

  localparam logic [BYTE_W-1:0] PREAMBLE_RST = 8'd254;
  localparam logic [BYTE_W-1:0] END_RST      = 8'd253;
  localparam logic [BYTE_W-1:0] CTRL_ADR_RST = 8'd224;
  localparam logic [BYTE_W-1:0] RADIO_ADR_RST = 8'd86;
  localparam logic [BYTE_W-1:0] NACK_RST     = 8'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREAMBLE   = 3'd0,
    REG_END        = 3'd1,
    REG_CTRL_ADDR  = 3'd2,
    REG_RADIO_ADDR = 3'd3,
    REG_NACK_CODE  = 3'd4
  } cfg_idx_e;

  // source of the next transmitted byte
  typedef enum logic [2:0] {
    SEL_PRE   = 3'd0,
    SEL_STORE = 3'd1,
    SEL_END   = 3'd2,
    SEL_CTRL  = 3'd3,
    SEL_RADIO = 3'd4,
    SEL_NACK  = 3'd5
  } sel_e;

  typedef struct packed {
    logic store_wr;   // write rx byte at count, count + 1
    logic count_clr;
    logic len_latch;  // stored length <= count, count <= 0
    logic len_clr;
    logic rd_rst;     // rewind store read pointer
    logic out_load;   // load output register
    sel_e out_sel;
    logic out_last;
    logic out_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             is_pre;
    logic             is_end;
    logic             count_full;
    logic             out_free;
    logic [LEN_W-1:0] length;
  } dp_sts_t;

endpackage

>>> hdl/cat_command_frame_receiver.sv
// Reply: a frame-ending or rejected byte passes through the FETCH and LOAD states to the output
//   register, where its first reply byte shows; bytes that only advance the receiver produce nothing.
// Throughput: 1 received byte per cycle while receiving; each reply byte passes through FETCH and LOAD,
//   paced by the registered command store read and by output stalls; input is held off while replying.
// Reset: asynchronous, active low; clears the receiver state, counters and the output valid
//   and loads register defaults. The command store is not cleared.
module cat_command_frame_receiver #(
  parameter int unsigned STORE_DEPTH = ccfr_pkg::STORE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [ccfr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ccfr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // received bytes
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [ccfr_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,  // [7:0] rx_byte
  // emitted frames
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [ccfr_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,  // [7:0] tx_byte,
                                                             // [13:8] command_length
  output logic                              m_axis_tlast_o,  // frame_last
  output logic [ccfr_pkg::M_TUSER_W-1:0]    m_axis_tuser_o   // [0] frame_kind (1 = NACK)
);
  import ccfr_pkg::*;

  ctrl_cmd_t         cmd;
  dp_sts_t           sts;
  logic [BYTE_W-1:0] tx_byte;
  logic              frame_kind;
  logic [LEN_W-1:0]  command_length;

  // Controller: receive phases (wait, second preamble, collecting) and reply sequencing.
  ccfr_ctrl #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: config registers, command store, counters and output register.
  ccfr_dp #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .rx_byte_i        (s_axis_tdata_i[BYTE_W-1:0]),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .tx_byte_o        (tx_byte),
    .frame_last_o     (m_axis_tlast_o),
    .frame_kind_o     (frame_kind),
    .command_length_o (command_length)
  );

  assign m_axis_tdata_o = {(M_TDATA_W - LEN_W - BYTE_W)'(0), command_length, tx_byte};
  assign m_axis_tuser_o = frame_kind;

  // NACK frames always carry a zero length
  a_nack_len_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (command_length == '0))
    else $error("NACK transaction with nonzero command_length");

  // stored length never exceeds the store depth
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.length <= LEN_W'(STORE_DEPTH)))
    else $error("stored length beyond store depth");

  // no input transaction while a reply byte is being loaded
  a_no_rx_in_reply : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(s_axis_tvalid_i && s_axis_tready_o))
    else $error("input accepted during reply");

endmodule

>>> hdl/ccfr_ctrl.sv
module ccfr_ctrl #(
  parameter int unsigned STORE_DEPTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ccfr_pkg::dp_sts_t    sts_i,
  output ccfr_pkg::ctrl_cmd_t  cmd_o
);
  import ccfr_pkg::*;

  localparam int unsigned PW = $clog2(STORE_DEPTH + 3);
  localparam logic [PW-1:0] POS_PRE2  = PW'(2);
  localparam logic [PW-1:0] POS_CTRL  = PW'(2);
  localparam logic [PW-1:0] POS_RADIO = PW'(3);
  localparam logic [PW-1:0] POS_NACK  = PW'(4);

  typedef enum logic [4:0] {
    ST_WAIT  = 5'b00001,
    ST_INIT  = 5'b00010,
    ST_RECV  = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_LOAD  = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          kind_q, kind_d;
  logic          in_acc;
  logic [PW-1:0] echo_end;

  assign in_ready_o = (state_q == ST_WAIT) || (state_q == ST_INIT) || (state_q == ST_RECV);
  assign in_acc     = in_valid_i && in_ready_o;
  assign echo_end   = PW'(sts_i.length) + POS_PRE2;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.out_sel  = SEL_PRE;
    cmd_o.out_kind = kind_q;

    // byte selection for the current frame position
    if (kind_q) begin
      case (pos_q)
        PW'(0), PW'(1): cmd_o.out_sel = SEL_PRE;
        POS_CTRL:       cmd_o.out_sel = SEL_CTRL;
        POS_RADIO:      cmd_o.out_sel = SEL_RADIO;
        POS_NACK:       cmd_o.out_sel = SEL_NACK;
        default: begin
          cmd_o.out_sel  = SEL_END;
          cmd_o.out_last = 1'b1;
        end
      endcase
    end else if (pos_q < POS_PRE2) begin
      cmd_o.out_sel = SEL_PRE;
    end else if (pos_q < echo_end) begin
      cmd_o.out_sel = SEL_STORE;
    end else begin
      cmd_o.out_sel  = SEL_END;
      cmd_o.out_last = 1'b1;
    end

    case (state_q)
      ST_WAIT: begin
        if (in_acc && sts_i.is_pre) state_d = ST_INIT;
      end
      ST_INIT: begin
        if (in_acc) begin
          if (sts_i.is_pre) begin
            state_d         = ST_RECV;
            cmd_o.count_clr = 1'b1;
          end else begin
            cmd_o.len_clr   = 1'b1;
            cmd_o.count_clr = 1'b1;
            kind_d  = 1'b1;
            pos_d   = '0;
            state_d = ST_FETCH;
          end
        end
      end
      ST_RECV: begin
        if (in_acc) begin
          if (sts_i.is_end) begin
            cmd_o.len_latch = 1'b1;
            cmd_o.rd_rst    = 1'b1;
            kind_d  = 1'b0;
            pos_d   = '0;
            state_d = ST_FETCH;
          end else if (!sts_i.count_full) begin
            cmd_o.store_wr = 1'b1;
          end else begin
            cmd_o.len_clr   = 1'b1;
            cmd_o.count_clr = 1'b1;
            kind_d  = 1'b1;
            pos_d   = '0;
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          pos_d   = pos_q + PW'(1);
          state_d = cmd_o.out_last ? ST_WAIT : ST_FETCH;
        end
      end
      default: state_d = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
      pos_q   <= '0;
      kind_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      kind_q  <= kind_d;
    end
  end

endmodule

>>> hdl/ccfr_dp.sv
module ccfr_dp #(
  parameter int unsigned STORE_DEPTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ccfr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic                                cfg_we_i,
  input  logic [ccfr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [ccfr_pkg::BYTE_W-1:0]         rx_byte_i,
  input  ccfr_pkg::ctrl_cmd_t                 cmd_i,
  output ccfr_pkg::dp_sts_t                   sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ccfr_pkg::BYTE_W-1:0]         tx_byte_o,
  output logic                                frame_last_o,
  output logic                                frame_kind_o,
  output logic [ccfr_pkg::LEN_W-1:0]          command_length_o
);
  import ccfr_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  logic [BYTE_W-1:0] pre_q, end_q, ctrl_adr_q, radio_adr_q, nack_q;
  logic [CW-1:0]     count_q, len_q;
  logic [AW-1:0]     rd_ptr_q;
  logic [BYTE_W-1:0] rd_data_q;
  logic [BYTE_W-1:0] store_mem [STORE_DEPTH];

  logic              valid_q;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q, kind_q;
  logic [LEN_W-1:0]  olen_q;
  logic [BYTE_W-1:0] byte_sel;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q       <= PREAMBLE_RST;
      end_q       <= END_RST;
      ctrl_adr_q  <= CTRL_ADR_RST;
      radio_adr_q <= RADIO_ADR_RST;
      nack_q      <= NACK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PREAMBLE:   pre_q       <= cfg_wdata_i;
        REG_END:        end_q       <= cfg_wdata_i;
        REG_CTRL_ADDR:  ctrl_adr_q  <= cfg_wdata_i;
        REG_RADIO_ADDR: radio_adr_q <= cfg_wdata_i;
        REG_NACK_CODE:  nack_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      len_q    <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (cmd_i.store_wr) count_q <= count_q + CW'(1);
      if (cmd_i.count_clr) count_q <= '0;
      if (cmd_i.len_latch) begin
        len_q   <= count_q;
        count_q <= '0;
      end
      if (cmd_i.len_clr) len_q <= '0;
      if (cmd_i.rd_rst) begin
        rd_ptr_q <= '0;
      end else if (cmd_i.out_load && cmd_i.out_sel == SEL_STORE) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
    end
  end

  // command store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) store_mem[count_q[AW-1:0]] <= rx_byte_i;
    rd_data_q <= store_mem[rd_ptr_q];
  end

  always_comb begin
    case (cmd_i.out_sel)
      SEL_PRE:   byte_sel = pre_q;
      SEL_STORE: byte_sel = rd_data_q;
      SEL_END:   byte_sel = end_q;
      SEL_CTRL:  byte_sel = ctrl_adr_q;
      SEL_RADIO: byte_sel = radio_adr_q;
      SEL_NACK:  byte_sel = nack_q;
      default:   byte_sel = end_q;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      byte_q <= byte_sel;
      last_q <= cmd_i.out_last;
      kind_q <= cmd_i.out_kind;
      olen_q <= LEN_W'(len_q);
    end
  end

  assign sts_o.is_pre     = (rx_byte_i == pre_q);
  assign sts_o.is_end     = (rx_byte_i == end_q);
  assign sts_o.count_full = (count_q == CW'(STORE_DEPTH));
  assign sts_o.out_free   = !valid_q || out_ready_i;
  assign sts_o.length     = LEN_W'(len_q);

  assign out_valid_o      = valid_q;
  assign tx_byte_o        = byte_q;
  assign frame_last_o     = last_q;
  assign frame_kind_o     = kind_q;
  assign command_length_o = olen_q;

endmodule

>>> verif/tb_cat_command_frame_receiver.sv
module tb_cat_command_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import ccfr_pkg::*;

  localparam int unsigned DEPTH = STORE_DEPTH_DEF;
  // Cycles to let the block settle once nothing more is expected.
  localparam int unsigned SETTLE_CYCLES = 20;
  // Long receiver hold-off, so the block backs up and stalls its input.
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // Register index with no register behind it; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  // Frames at reset settings, byte 0 in the low bits.
  localparam logic [5:0][7:0] NACK_AT_RESET =
    {8'hFD, 8'hFA, 8'h56, 8'hE0, 8'hFE, 8'hFE};
  localparam logic [5:0][7:0] EMPTY_ECHO_AT_RESET =
    {24'h0, 8'hFD, 8'hFE, 8'hFE};

  typedef struct packed {
    logic [7:0] pre;
    logic [7:0] eof;
    logic [7:0] ctrl;
    logic [7:0] radio;
    logic [7:0] nack;
  } settings_t;

  typedef struct packed {
    logic [7:0]       tx_byte;
    logic             frame_last;
    logic             frame_kind;   // 1 = NACK
    logic [LEN_W-1:0] cmd_len;
  } reply_t;

  // Directed row: a received byte and, where it is obvious, the frame it must give.
  typedef struct {
    logic [7:0]      rx;
    int unsigned     typed_n;       // 0: predictor decides
    logic [5:0][7:0] typed_b;
    logic            typed_kind;
  } dir_row_t;

  typedef enum logic [1:0] {
    RX_HUNT,
    RX_SECOND,
    RX_BODY
  } rx_phase_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [S_TDATA_W-1:0]   s_axis_tdata_i;   // [7:0] rx_byte
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [M_TDATA_W-1:0]   m_axis_tdata_o;   // [7:0] tx_byte, [13:8] command_length
  logic                   m_axis_tlast_o;   // frame_last
  logic [M_TUSER_W-1:0]   m_axis_tuser_o;   // [0] frame_kind

  cat_command_frame_receiver DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Predictor state: a private copy of the receiver and its registers.
  settings_t   cfg;
  rx_phase_e   rx_phase;
  int unsigned body_cnt;
  int unsigned last_len;
  logic [7:0]  cmd_mem [DEPTH];

  reply_t      frame_q[$];   // frame bytes produced by the latest received byte
  reply_t      reply_q[$];   // frame bytes still owed by the block, oldest first
  int unsigned mismatch_cnt;
  bit          no_idle;      // suppresses gaps on both sides

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Any correct run ends far sooner than this.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Mostly short gaps, a few long ones, none at all while no_idle is set.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_reply(input logic [7:0] b, input logic last,
                                    input logic kind, input int unsigned len);
    frame_q.push_back('{b, last, kind, len[LEN_W-1:0]});
  endfunction

  // Rejection: back to hunting, store forgotten, six-byte NACK frame.
  function automatic void emit_nack();
    last_len = 0;
    body_cnt = 0;
    rx_phase = RX_HUNT;
    add_reply(cfg.pre,   1'b0, 1'b1, 0);
    add_reply(cfg.pre,   1'b0, 1'b1, 0);
    add_reply(cfg.ctrl,  1'b0, 1'b1, 0);
    add_reply(cfg.radio, 1'b0, 1'b1, 0);
    add_reply(cfg.nack,  1'b0, 1'b1, 0);
    add_reply(cfg.eof,   1'b1, 1'b1, 0);
  endfunction

  // One received byte through the frame receiver; any reply lands in frame_q.
  function automatic void decode_rx_byte(input logic [7:0] b);
    case (rx_phase)
      RX_SECOND: begin
        if (b == cfg.pre) begin
          rx_phase = RX_BODY;
          body_cnt = 0;
        end else begin
          emit_nack();
        end
      end
      RX_BODY: begin
        if (b == cfg.eof) begin
          // Echo: preamble twice, the stored command, end byte.
          last_len = body_cnt;
          body_cnt = 0;
          rx_phase = RX_HUNT;
          add_reply(cfg.pre, 1'b0, 1'b0, last_len);
          add_reply(cfg.pre, 1'b0, 1'b0, last_len);
          for (int unsigned i = 0; i < last_len; i++)
            add_reply(cmd_mem[i], 1'b0, 1'b0, last_len);
          add_reply(cfg.eof, 1'b1, 1'b0, last_len);
        end else if (body_cnt < DEPTH) begin
          // Preamble bytes inside a command are plain data.
          cmd_mem[body_cnt] = b;
          body_cnt++;
        end else begin
          // Store full: the byte is dropped and the frame rejected.
          emit_nack();
        end
      end
      default: rx_phase = (b == cfg.pre) ? RX_SECOND : RX_HUNT;
    endcase
  endfunction

  // Offer one byte, wait for its transaction, then book the reply it owes.
  // tvalid is left high afterwards; the next call or drain() lowers it, so it
  // never gets two assignments in one time step.
  task automatic send_rx(input logic [7:0] b, input int unsigned typed_n = 0,
                         input logic [5:0][7:0] typed_b = '0,
                         input logic typed_kind = 1'b0);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);

    frame_q.delete();
    decode_rx_byte(b);
    if (typed_n != 0) begin
      // Hand-typed frame stands in for the predicted one.
      for (int unsigned i = 0; i < typed_n; i++)
        reply_q.push_back('{typed_b[i], i == typed_n - 1, typed_kind, '0});
    end else begin
      foreach (frame_q[i]) reply_q.push_back(frame_q[i]);
    end
  endtask

  // Well-formed frame: two preambles, len data bytes, end byte. Data avoids
  // the end byte unless it happens to be the preamble as well.
  task automatic send_frame(input int unsigned len);
    logic [7:0] b;
    send_rx(cfg.pre);
    send_rx(cfg.pre);
    for (int unsigned k = 0; k < len; k++) begin
      b = ($urandom_range(0, 7) == 0) ? cfg.pre : 8'($urandom_range(0, 255));
      if (b == cfg.eof && b != cfg.pre) b = ~b;
      send_rx(b);
    end
    send_rx(cfg.eof);
  endtask

  // Random traffic: mostly frames with random content, some with a bad second
  // byte, some line noise. force_long adds a full store and an overflow first.
  task automatic run_random(input int unsigned n_items, input bit force_long);
    int unsigned sent;
    int unsigned r;
    int unsigned len;
    logic [7:0]  b;
    sent = 0;
    if (force_long) begin
      send_frame(DEPTH);
      send_frame(DEPTH + 2);
      sent = 2 * DEPTH + 8;
    end
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        r = $urandom_range(0, 99);
        if (r < 80)      len = $urandom_range(0, 6);
        else if (r < 92) len = $urandom_range(7, DEPTH - 1);
        else             len = $urandom_range(DEPTH, DEPTH + 2);
        send_frame(len);
        sent += len + 3;
      end else if (r < 85) begin
        b = 8'($urandom_range(0, 255));
        if (b == cfg.pre) b = ~b;
        send_rx(cfg.pre);
        send_rx(b);
        sent += 2;
      end else begin
        // Noise: mostly ignored, so not counted.
        send_rx(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Stop offering, wait for every owed byte, then let the block go quiet.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // All five registers, plus a write to an index with no register behind it.
  task automatic load_settings(input settings_t s);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_PREAMBLE;   cfg_wdata_i <= s.pre;   @(posedge clk_i);
    cfg_idx_i <= REG_END;        cfg_wdata_i <= s.eof;   @(posedge clk_i);
    cfg_idx_i <= REG_CTRL_ADDR;  cfg_wdata_i <= s.ctrl;  @(posedge clk_i);
    cfg_idx_i <= REG_RADIO_ADDR; cfg_wdata_i <= s.radio; @(posedge clk_i);
    cfg_idx_i <= REG_NACK_CODE;  cfg_wdata_i <= s.nack;  @(posedge clk_i);
    cfg_idx_i <= CFG_IDX_UNUSED; cfg_wdata_i <= ~s.pre;  @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg = s;
  endtask

  // Receiver side: random stalls, and once, after some traffic, a long
  // hold-off while the sender keeps offering bytes.
  initial begin : frame_sink
    int unsigned seen;
    int unsigned stall;
    bit          held;
    seen  = 0;
    stall = 0;
    held  = 1'b0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) seen++;
      if (!held && seen >= 40) begin
        held  = 1'b1;
        stall = HOLD_OFF_CYCLES;
      end else if (stall == 0 && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Every output transaction against the oldest owed byte, field by field.
  always @(posedge clk_i) begin : reply_check
    reply_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (reply_q.size() == 0) begin
        $error("unexpected output transaction: tdata %0h", m_axis_tdata_o);
        mismatch_cnt++;
      end else begin
        exp_r = reply_q.pop_front();
        if (m_axis_tdata_o[7:0] !== exp_r.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", exp_r.tx_byte, m_axis_tdata_o[7:0]);
          mismatch_cnt++;
        end
        if (m_axis_tdata_o[13:8] !== exp_r.cmd_len) begin
          $error("command_length: expected %0d, got %0d", exp_r.cmd_len,
                 m_axis_tdata_o[13:8]);
          mismatch_cnt++;
        end
        if (m_axis_tlast_o !== exp_r.frame_last) begin
          $error("frame_last: expected %0b, got %0b", exp_r.frame_last, m_axis_tlast_o);
          mismatch_cnt++;
        end
        if (m_axis_tuser_o[0] !== exp_r.frame_kind) begin
          $error("frame_kind: expected %0b, got %0b", exp_r.frame_kind, m_axis_tuser_o[0]);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t  dir_tab [17];
    settings_t s;

    mismatch_cnt = 0;
    no_idle      = 1'b0;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_PREAMBLE;
    cfg_wdata_i     <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;

    cfg      = '{PREAMBLE_RST, END_RST, CTRL_ADR_RST, RADIO_ADR_RST, NACK_RST};
    rx_phase = RX_HUNT;
    body_cnt = 0;
    last_len = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings (preamble FE, end FD).
    dir_tab = '{
      '{8'h00, 0, '0, 1'b0},                      // noise while hunting: ignored
      '{8'hFF, 0, '0, 1'b0},
      '{8'hFE, 0, '0, 1'b0},                      // bad second byte
      '{8'h00, 6, NACK_AT_RESET, 1'b1},
      '{8'hFE, 0, '0, 1'b0},                      // empty command
      '{8'hFE, 0, '0, 1'b0},
      '{8'hFD, 3, EMPTY_ECHO_AT_RESET, 1'b0},
      '{8'hFE, 0, '0, 1'b0},                      // command holding extremes and
      '{8'hFE, 0, '0, 1'b0},                      // a preamble byte as data
      '{8'h00, 0, '0, 1'b0},
      '{8'hFF, 0, '0, 1'b0},
      '{8'hFE, 0, '0, 1'b0},
      '{8'h55, 0, '0, 1'b0},
      '{8'hAA, 0, '0, 1'b0},
      '{8'hFD, 0, '0, 1'b0},
      '{8'hFE, 0, '0, 1'b0},                      // end byte in second place
      '{8'hFD, 6, NACK_AT_RESET, 1'b1}
    };
    foreach (dir_tab[i])
      send_rx(dir_tab[i].rx, dir_tab[i].typed_n, dir_tab[i].typed_b, dir_tab[i].typed_kind);
    run_random(40, 1'b1);
    drain();

    // Low extremes for preamble, control address and code; high end byte and radio address.
    load_settings('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
    run_random(25, 1'b0);
    drain();

    // The opposite extremes, with back-to-back traffic on both sides.
    no_idle = 1'b1;
    load_settings('{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
    run_random(25, 1'b0);
    drain();
    no_idle = 1'b0;

    s = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
          8'($urandom_range(0, 255))};
    load_settings(s);
    run_random(25, 1'b0);
    drain();

    // Preamble equal to the end byte: a second preamble never ends a frame,
    // but any later one does.
    s.pre = 8'h7E;
    s.eof = 8'h7E;
    load_settings(s);
    run_random(25, 1'b0);
    drain();

    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
